FILE: design/qmra_pkg.sv
// qmra_pkg: shared types and codes for the quadratic model residual accumulator
// word layouts, opcodes and the controller-to-datapath command codes
// no dependencies
package qmra_pkg;

    // default sizes handed to the top level parameters
    localparam int NUM_CHANNELS_DEF = 2;
    localparam int NUM_MODES_DEF    = 2;

    // opcodes of an input word
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_COORD = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // datapath step codes
    localparam int DP_OP_W = 5;
    localparam logic [DP_OP_W-1:0] DP_NOP   = 5'd0;
    localparam logic [DP_OP_W-1:0] DP_LOAD  = 5'd1;
    localparam logic [DP_OP_W-1:0] DP_CRD   = 5'd2;
    localparam logic [DP_OP_W-1:0] DP_CMUL  = 5'd3;
    localparam logic [DP_OP_W-1:0] DP_CACC  = 5'd4;
    localparam logic [DP_OP_W-1:0] DP_CCNT  = 5'd5;
    localparam logic [DP_OP_W-1:0] DP_ERD0  = 5'd6;
    localparam logic [DP_OP_W-1:0] DP_EW0   = 5'd7;
    localparam logic [DP_OP_W-1:0] DP_ERD   = 5'd8;
    localparam logic [DP_OP_W-1:0] DP_EAMP  = 5'd9;
    localparam logic [DP_OP_W-1:0] DP_EMAG  = 5'd10;
    localparam logic [DP_OP_W-1:0] DP_ESQ   = 5'd11;
    localparam logic [DP_OP_W-1:0] DP_EADD  = 5'd12;
    localparam logic [DP_OP_W-1:0] DP_RSAT  = 5'd13;
    localparam logic [DP_OP_W-1:0] DP_RDIFF = 5'd14;
    localparam logic [DP_OP_W-1:0] DP_RSQ   = 5'd15;
    localparam logic [DP_OP_W-1:0] DP_RDIST = 5'd16;
    localparam logic [DP_OP_W-1:0] DP_ROUT  = 5'd17;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [5:0]          param_index;
        logic signed [31:0]  param_value;
        logic signed [31:0]  coord_value;
        logic signed [31:0]  measured_intensity;
        logic                last_sample;
    } item_t;

    typedef struct packed {
        logic signed [31:0]  model_intensity;
        logic [62:0]         distance;
        logic                batch_done;
        logic                count_error;
    } result_t;

    typedef struct packed {
        logic                capture;
        logic [DP_OP_W-1:0]  op;
    } cmd_t;

    typedef struct packed {
        logic                coord_ok;
        logic                last_ch;
        logic                out_free;
    } status_t;

endpackage

FILE: design/qmra_ctrl.sv
// qmra_ctrl: sequencer for the quadratic model residual accumulator
// steps the datapath through load, coordinate and end-of-sample work
// depends on qmra_pkg
module qmra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [1:0]        opcode,
    output logic              item_stall,
    input  qmra_pkg::status_t status,
    output qmra_pkg::cmd_t    cmd
);
    import qmra_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOAD  = 5'd1;
    localparam logic [4:0] S_CRD   = 5'd2;
    localparam logic [4:0] S_CMUL  = 5'd3;
    localparam logic [4:0] S_CACC  = 5'd4;
    localparam logic [4:0] S_CCNT  = 5'd5;
    localparam logic [4:0] S_ERD0  = 5'd6;
    localparam logic [4:0] S_EW0   = 5'd7;
    localparam logic [4:0] S_ERD   = 5'd8;
    localparam logic [4:0] S_EAMP  = 5'd9;
    localparam logic [4:0] S_EMAG  = 5'd10;
    localparam logic [4:0] S_ESQ   = 5'd11;
    localparam logic [4:0] S_EADD  = 5'd12;
    localparam logic [4:0] S_RSAT  = 5'd13;
    localparam logic [4:0] S_RDIFF = 5'd14;
    localparam logic [4:0] S_RSQ   = 5'd15;
    localparam logic [4:0] S_RDIST = 5'd16;
    localparam logic [4:0] S_ROUT  = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = (state_reg == S_IDLE) && item_valid;
        cmd.op      = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (opcode)
                        OP_LOAD:  state_next = S_LOAD;
                        OP_COORD: state_next = status.coord_ok ? S_CRD : S_CCNT;
                        OP_END:   state_next = S_ERD0;
                        OP_NONE:  state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.op     = DP_LOAD;
                state_next = S_IDLE;
            end
            S_CRD:
            begin
                cmd.op     = DP_CRD;
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                cmd.op     = DP_CMUL;
                state_next = S_CACC;
            end
            S_CACC:
            begin
                cmd.op     = DP_CACC;
                state_next = status.last_ch ? S_CCNT : S_CRD;
            end
            S_CCNT:
            begin
                cmd.op     = DP_CCNT;
                state_next = S_IDLE;
            end
            S_ERD0:
            begin
                cmd.op     = DP_ERD0;
                state_next = S_EW0;
            end
            S_EW0:
            begin
                cmd.op     = DP_EW0;
                state_next = S_ERD;
            end
            S_ERD:
            begin
                cmd.op     = DP_ERD;
                state_next = S_EAMP;
            end
            S_EAMP:
            begin
                cmd.op     = DP_EAMP;
                state_next = S_EMAG;
            end
            S_EMAG:
            begin
                cmd.op     = DP_EMAG;
                state_next = S_ESQ;
            end
            S_ESQ:
            begin
                cmd.op     = DP_ESQ;
                state_next = S_EADD;
            end
            S_EADD:
            begin
                cmd.op     = DP_EADD;
                state_next = status.last_ch ? S_RSAT : S_ERD;
            end
            S_RSAT:
            begin
                cmd.op     = DP_RSAT;
                state_next = S_RDIFF;
            end
            S_RDIFF:
            begin
                cmd.op     = DP_RDIFF;
                state_next = S_RSQ;
            end
            S_RSQ:
            begin
                cmd.op     = DP_RSQ;
                state_next = S_RDIST;
            end
            S_RDIST:
            begin
                cmd.op     = DP_RDIST;
                state_next = S_ROUT;
            end
            S_ROUT:
            begin
                // hold here until the result register can take the word
                if (status.out_free)
                begin
                    cmd.op     = DP_ROUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/qmra_dp.sv
// qmra_dp: datapath of the quadratic model residual accumulator
// model word store, channel amplitudes, multipliers, distance and result register
// depends on qmra_pkg
module qmra_dp #(
    parameter int NUM_CHANNELS = qmra_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_MODES    = qmra_pkg::NUM_MODES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  qmra_pkg::cmd_t    cmd,
    output qmra_pkg::status_t status,
    input  qmra_pkg::item_t   item,
    input  logic              result_stall,
    output logic              result_valid,
    output qmra_pkg::result_t result
);
    import qmra_pkg::*;

    localparam int STRIDE    = 1 + NUM_MODES;
    localparam int NUM_WORDS = 1 + NUM_CHANNELS * STRIDE;
    localparam int AW        = $clog2(NUM_WORDS);
    localparam int CW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SUM_W     = 34 + $clog2(NUM_CHANNELS);

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v[48] != v[47])
        begin
            return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return v[47:0];
    endfunction

    item_t                    item_reg;
    logic [31:0]              mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]     valid_reg;
    logic [AW-1:0]            rd_addr;
    logic signed [31:0]       rdata_reg;
    logic [CW-1:0]            ch_reg;
    logic [3:0]               count_reg;
    logic signed [47:0]       amp_reg [NUM_CHANNELS];
    logic signed [63:0]       prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     high_reg;
    logic signed [47:0]       a_reg;
    logic [47:0]              mag_reg;
    logic [47:0]              sq_reg;
    logic                     small_reg;
    logic signed [31:0]       model_reg;
    logic [31:0]              dmag_reg;
    logic [63:0]              dsq_reg;
    logic [62:0]              dist_reg;
    logic [62:0]              dist_new_reg;
    result_t                  result_reg;
    logic                     result_valid_reg;

    logic                     load_ok;
    logic                     out_free;
    logic signed [48:0]       cacc_sum;
    logic signed [48:0]       eamp_sum;
    logic signed [32:0]       diff;
    logic [64:0]              dist_sum;

    assign load_ok  = item_reg.param_index < 6'(NUM_WORDS);
    assign out_free = !result_valid_reg || !result_stall;

    assign status.coord_ok = count_reg < 4'(NUM_MODES);
    assign status.last_ch  = ch_reg == CW'(NUM_CHANNELS - 1);
    assign status.out_free = out_free;

    assign cacc_sum = {amp_reg[ch_reg][47], amp_reg[ch_reg]}
                    + {prod_reg[63], prod_reg[63:16]};
    assign eamp_sum = 49'(rdata_reg) + {amp_reg[ch_reg][47], amp_reg[ch_reg]};
    assign diff     = {item_reg.measured_intensity[31], item_reg.measured_intensity}
                    - {model_reg[31], model_reg};
    assign dist_sum = {2'b00, dist_reg} + {1'b0, dsq_reg};

    // word address of the step in flight
    always_comb
    begin
        unique case (cmd.op)
            DP_CRD:  rd_addr = AW'(2 + int'(ch_reg) * STRIDE + int'(count_reg));
            DP_ERD:  rd_addr = AW'(1 + int'(ch_reg) * STRIDE);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    // model word store, never-written words read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD && load_ok)
        begin
            mem[item_reg.param_index[AW-1:0]] <= item_reg.param_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.op == DP_LOAD && load_ok)
        begin
            valid_reg[item_reg.param_index[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg           <= '0;
            count_reg        <= '0;
            dist_reg         <= '0;
            result_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                amp_reg[c] <= '0;
            end
        end
        else
        begin
            // a new word may replace one taken in the same cycle
            if (cmd.op == DP_ROUT)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                DP_CACC:
                begin
                    amp_reg[ch_reg] <= sat48(cacc_sum);
                    ch_reg          <= status.last_ch ? '0 : ch_reg + 1'b1;
                end
                DP_EADD:
                begin
                    ch_reg <= status.last_ch ? '0 : ch_reg + 1'b1;
                end
                DP_CCNT:
                begin
                    if (count_reg != 4'hf)
                    begin
                        count_reg <= count_reg + 4'd1;
                    end
                end
                DP_ROUT:
                begin
                    count_reg        <= '0;
                    dist_reg         <= item_reg.last_sample ? '0 : dist_new_reg;
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        amp_reg[c] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CMUL:
            begin
                prod_reg <= rdata_reg * item_reg.coord_value;
            end
            DP_EW0:
            begin
                acc_reg  <= SUM_W'(rdata_reg);
                high_reg <= 1'b0;
            end
            DP_EAMP:
            begin
                a_reg <= sat48(eamp_sum);
            end
            DP_EMAG:
            begin
                mag_reg <= a_reg[47] ? 48'(-a_reg) : 48'(a_reg);
            end
            DP_ESQ:
            begin
                sq_reg    <= mag_reg[23:0] * mag_reg[23:0];
                small_reg <= mag_reg[47:24] == '0;
            end
            DP_EADD:
            begin
                if (small_reg)
                begin
                    acc_reg <= acc_reg + SUM_W'({1'b0, sq_reg[47:16]});
                end
                else
                begin
                    high_reg <= 1'b1;
                end
            end
            DP_RSAT:
            begin
                // in range when no square overflowed and bits 31 and up all match the sign
                if (high_reg || (acc_reg[SUM_W-1:31] != '0 && !acc_reg[SUM_W-1]))
                begin
                    model_reg <= 32'sh7fff_ffff;
                end
                else if (acc_reg[SUM_W-1:31] != '1 && acc_reg[SUM_W-1])
                begin
                    model_reg <= 32'sh8000_0000;
                end
                else
                begin
                    model_reg <= acc_reg[31:0];
                end
            end
            DP_RDIFF:
            begin
                dmag_reg <= diff[32] ? 32'(-diff) : diff[31:0];
            end
            DP_RSQ:
            begin
                dsq_reg <= dmag_reg * dmag_reg;
            end
            DP_RDIST:
            begin
                dist_new_reg <= (dist_sum[64:63] != 2'b00) ? '1 : dist_sum[62:0];
            end
            DP_ROUT:
            begin
                result_reg.model_intensity <= model_reg;
                result_reg.distance        <= dist_new_reg;
                result_reg.batch_done      <= item_reg.last_sample;
                result_reg.count_error     <= count_reg != 4'(NUM_MODES);
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: design/quadratic_model_residual_accumulator.sv
// quadratic_model_residual_accumulator: top level
// joins the qmra_ctrl sequencer and the qmra_dp datapath
// depends on qmra_pkg, qmra_ctrl, qmra_dp
//
//   channel   direction  handshake                     word
//   item      in         item_valid / item_stall       qmra_pkg::item_t
//   result    out        result_valid / result_stall   qmra_pkg::result_t
//
// one item at a time; item_stall is high while an item is being worked on
// work per item: a model word load is a store step; a coordinate runs read /
//   multiply / accumulate for each channel, then counts the mode (the count
//   alone once all modes are in); all on one datapath, channel by channel
// an end of sample waits in its last step while a result is still held
// async active-low reset clears the word store valid bits, amplitudes and distance
// the result register lets the next item in while a result waits to be taken
module quadratic_model_residual_accumulator #(
    parameter int NUM_CHANNELS = qmra_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_MODES    = qmra_pkg::NUM_MODES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  qmra_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output qmra_pkg::result_t result
);
    import qmra_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: one state per datapath step
    qmra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .opcode     (item.opcode),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: word store, amplitudes, squares, distance, result register
    qmra_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_MODES    (NUM_MODES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: design/qmra_checker.sv
// qmra_checker: port-level checks for the quadratic model residual accumulator
// bound to the top level below
// depends on qmra_pkg
module qmra_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input qmra_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input qmra_pkg::result_t result
);
    import qmra_pkg::*;

    // a held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

    // any real item keeps the block busy the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.opcode != OP_NONE |=> item_stall)
    else $error("block took a new word right after a real item");

    // a new result only shows up at the end of busy work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without an item in progress");

    // loads, coordinates and no-op words never produce a result the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.opcode != OP_END |=> !$rose(result_valid))
    else $error("result produced by a non end-of-sample word");

endmodule

bind quadratic_model_residual_accumulator qmra_checker u_qmra_checker (.*);
